/* rtl/core/message_hash_presence_cache_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the message hash presence cache
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_HASH_PRESENCE_CACHE_UNIT_DEFINES_SVH
`define MESSAGE_HASH_PRESENCE_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MSH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication.
`define MSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

/* rtl/core/msh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message hash presence cache package
// Opcodes, answer codes, widths and the command record shared by the channels and the cache modules other than the RAM.
// ----------------------------------------------------------------------------
package msh_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 4096;
  localparam int CFG_W  = 13;
  localparam int HASH_W = 64;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 32;
  // Stored word: valid, present, hash high, hash low.
  localparam int WORD_W = 2 + 2 * HASH_W;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] RES_POS  = 2'd0;
  localparam logic [1:0] RES_NEG  = 2'd1;
  localparam logic [1:0] RES_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [HASH_W-1:0] hash_high;
    logic [HASH_W-1:0] hash_low;
    logic              store_found;
    logic              enable;
  } cmd_t;

endpackage

/* rtl/core/msh_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one cache request per transaction.
// ----------------------------------------------------------------------------
interface msh_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [msh_pkg::HASH_W-1:0] hash_high;
  logic [msh_pkg::HASH_W-1:0] hash_low;
  logic                      store_found;

  modport source (output valid, opcode, hash_high, hash_low, store_found, input ready);
  modport sink   (input valid, opcode, hash_high, hash_low, store_found, output ready);
endinterface

/* rtl/core/msh_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one answer and the four counters per transaction.
// ----------------------------------------------------------------------------
interface msh_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 lookup_result;
  logic [msh_pkg::STAT_W-1:0] positive_hits;
  logic [msh_pkg::STAT_W-1:0] negative_hits;
  logic [msh_pkg::STAT_W-1:0] store_present;
  logic [msh_pkg::STAT_W-1:0] store_absent;

  modport source (output valid, lookup_result, positive_hits, negative_hits,
                  store_present, store_absent, input ready);
  modport sink   (input valid, lookup_result, positive_hits, negative_hits,
                  store_present, store_absent, output ready);
endinterface

/* rtl/core/msh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    re,
  input  logic [ADDR_W-1:0]       raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* rtl/core/msh_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache front end
// Accepts requests, holds the entry count and works out the slot index by a
// bit-serial remainder of the key by the entry count.
// ----------------------------------------------------------------------------
module msh_front #(
  parameter int MAX_ENTRIES = msh_pkg::DEFAULT_MAX_ENTRIES,
  parameter int SLOT_W      = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [msh_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      clearing,
  msh_in_if.sink                    in_ch,
  input  logic                      q_full,
  output logic                      q_push,
  output msh_pkg::cmd_t             q_cmd,
  output logic [SLOT_W-1:0]         q_slot
);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int DIV_W = $clog2(msh_pkg::KEY_W);
  localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(msh_pkg::KEY_W - 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [msh_pkg::CFG_W-1:0]  cfg_entries_r;
  msh_pkg::cmd_t              cmd_r;
  logic [msh_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]           n_r;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [DIV_W-1:0]           div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]           n_cur;
  logic [CNT_W:0]             rem_sh, rem_dif;
  logic                       accept;
  logic                       needs_slot;

  // Entry counts above the store size are clipped to it.
  always_comb begin
    if (32'(cfg_entries_r) > 32'(MAX_ENTRIES)) begin
      n_cur = CNT_W'(MAX_ENTRIES);
    end else begin
      n_cur = CNT_W'(cfg_entries_r);
    end
  end

  assign in_ch.ready = (state_r == F_IDLE) && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;
  assign needs_slot  = (in_ch.opcode != msh_pkg::OP_READ) && (n_cur != '0);

  // One restoring step per cycle, key bits taken most significant first.
  assign rem_sh  = {rem_r, key_r[msh_pkg::KEY_W-1]};
  assign rem_dif = rem_sh - {1'b0, n_r};

  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          key_nxt     = in_ch.hash_low[2*msh_pkg::KEY_W-1:msh_pkg::KEY_W];
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = needs_slot ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        key_nxt     = {key_r[msh_pkg::KEY_W-2:0], 1'b0};
        rem_nxt     = (rem_sh >= {1'b0, n_r}) ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= F_IDLE;
      cfg_entries_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_entries_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (accept) begin
      n_r               <= n_cur;
      cmd_r.op          <= in_ch.opcode;
      cmd_r.hash_high   <= in_ch.hash_high;
      cmd_r.hash_low    <= in_ch.hash_low;
      cmd_r.store_found <= in_ch.store_found;
      cmd_r.enable      <= (n_cur != '0);
    end
  end

  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_cmd  = cmd_r;
  // The remainder is below the clipped entry count, so it fits the slot index.
  assign q_slot = rem_r[SLOT_W-1:0];
endmodule

/* rtl/core/msh_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module msh_queue #(
  parameter int SLOT_W = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msh_pkg::cmd_t     push_cmd,
  input  logic [SLOT_W-1:0] push_slot,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output msh_pkg::cmd_t     head_cmd,
  output logic [SLOT_W-1:0] head_slot
);
  msh_pkg::cmd_t     cmd_q_r  [2];
  logic [SLOT_W-1:0] slot_q_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;

  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);
  assign head_cmd  = cmd_q_r[rd_ptr_r];
  assign head_slot = slot_q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r]  <= push_cmd;
      slot_q_r[wr_ptr_r] <= push_slot;
    end
  end
endmodule

/* rtl/core/msh_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache back end
// Owns the slot store and the statistics counters, clears the store after
// reset and produces one result per command.
// ----------------------------------------------------------------------------
`include "message_hash_presence_cache_unit_defines.svh"

module msh_back #(
  parameter int MAX_ENTRIES = msh_pkg::DEFAULT_MAX_ENTRIES,
  parameter int SLOT_W      = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              clearing,
  input  logic              q_empty,
  input  msh_pkg::cmd_t     q_cmd,
  input  logic [SLOT_W-1:0] q_slot,
  output logic              q_pop,
  msh_out_if.source         out_ch
);
  localparam int HW = msh_pkg::HASH_W;
  localparam int WW = msh_pkg::WORD_W;
  localparam logic [SLOT_W-1:0] CLR_LAST = SLOT_W'(MAX_ENTRIES - 1);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_CMP  = 1'b1;

  logic                       state_r, state_nxt;
  logic                       clr_busy_r;
  logic [SLOT_W-1:0]          clr_addr_r;
  msh_pkg::cmd_t              cur_r;
  logic [msh_pkg::STAT_W-1:0] pos_r, neg_r, pfill_r, afill_r;
  logic [msh_pkg::STAT_W-1:0] pos_nxt, neg_nxt, pfill_nxt, afill_nxt;
  logic [msh_pkg::STAT_W-1:0] o_pos, o_neg, o_pfill, o_afill;
  logic [1:0]                 o_res;
  logic                       load_out;
  logic                       out_valid_r;
  logic [1:0]                 out_res_r;
  logic [msh_pkg::STAT_W-1:0] out_pos_r, out_neg_r, out_pfill_r, out_afill_r;

  logic                       ram_we, ram_re;
  logic [SLOT_W-1:0]          ram_waddr;
  logic [WW-1:0]              ram_wdata, ram_rdata;
  logic                       is_write, hit;

  assign clearing = clr_busy_r;
  assign q_pop    = !clr_busy_r && (state_r == B_IDLE) && !q_empty && !out_valid_r;
  assign is_write = (q_cmd.op == msh_pkg::OP_FILL) || (q_cmd.op == msh_pkg::OP_INSERT);

  // During the clearing pass every slot is written with an all-zero word.
  assign ram_we    = clr_busy_r || (q_pop && is_write && q_cmd.enable);
  assign ram_waddr = clr_busy_r ? clr_addr_r : q_slot;
  always_comb begin
    if (clr_busy_r) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = {1'b1,
                   (q_cmd.op == msh_pkg::OP_INSERT) ? 1'b1 : q_cmd.store_found,
                   q_cmd.hash_high, q_cmd.hash_low};
    end
  end
  assign ram_re = q_pop && (q_cmd.op == msh_pkg::OP_LOOKUP) && q_cmd.enable;

  msh_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_slot),
    .rdata (ram_rdata)
  );

  assign hit = ram_rdata[WW-1]
            && (ram_rdata[2*HW-1:HW] == cur_r.hash_high)
            && (ram_rdata[HW-1:0] == cur_r.hash_low);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;
    pfill_nxt = pfill_r;
    afill_nxt = afill_r;
    load_out  = 1'b0;
    o_res     = msh_pkg::RES_NONE;
    o_pos     = pos_r;
    o_neg     = neg_r;
    o_pfill   = pfill_r;
    o_afill   = afill_r;
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          case (q_cmd.op)
            msh_pkg::OP_LOOKUP: begin
              if (q_cmd.enable) begin
                state_nxt = B_CMP;
              end else begin
                load_out = 1'b1;
              end
            end
            msh_pkg::OP_FILL: begin
              load_out = 1'b1;
              if (q_cmd.store_found) begin
                pfill_nxt = pfill_r + 1'b1;
              end else begin
                afill_nxt = afill_r + 1'b1;
              end
              o_pfill = pfill_nxt;
              o_afill = afill_nxt;
            end
            msh_pkg::OP_INSERT: begin
              load_out = 1'b1;
            end
            default: begin
              // Counter read: report the values, then clear them.
              load_out  = 1'b1;
              pos_nxt   = '0;
              neg_nxt   = '0;
              pfill_nxt = '0;
              afill_nxt = '0;
            end
          endcase
        end
      end
      B_CMP: begin
        load_out  = 1'b1;
        state_nxt = B_IDLE;
        if (hit) begin
          if (ram_rdata[WW-2]) begin
            pos_nxt = pos_r + 1'b1;
            o_res   = msh_pkg::RES_POS;
          end else begin
            neg_nxt = neg_r + 1'b1;
            o_res   = msh_pkg::RES_NEG;
          end
        end
        o_pos = pos_nxt;
        o_neg = neg_nxt;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      neg_r       <= '0;
      pfill_r     <= '0;
      afill_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      neg_r   <= neg_nxt;
      pfill_r <= pfill_nxt;
      afill_r <= afill_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (load_out) begin
      out_res_r   <= o_res;
      out_pos_r   <= o_pos;
      out_neg_r   <= o_neg;
      out_pfill_r <= o_pfill;
      out_afill_r <= o_afill;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.lookup_result = out_res_r;
  assign out_ch.positive_hits = out_pos_r;
  assign out_ch.negative_hits = out_neg_r;
  assign out_ch.store_present = out_pfill_r;
  assign out_ch.store_absent  = out_afill_r;

  `MSH_ASSERT_NOW(a_no_pop_while_clearing, clk, rst_n, clr_busy_r, !q_pop)
  `MSH_ASSERT_NOW(a_clear_writes_zero, clk, rst_n, clr_busy_r, ram_we && (ram_wdata == '0))
  `MSH_ASSERT_NEXT(a_read_then_compare, clk, rst_n, ram_re, state_r == B_CMP)
  `MSH_ASSERT_NOW(a_load_into_free_slot, clk, rst_n, load_out, !out_valid_r)
endmodule

/* rtl/core/message_hash_presence_cache_unit.sv */
`timescale 1ns / 1ps
// Path from request to result: 32 remainder steps, the queue, the store access.
// The front end takes a new request only after it has pushed the last one to the queue.
// Counter reads and requests with the cache disabled skip the remainder steps.
// Reset: synchronous, active low; afterwards the slot store is cleared one slot per
// cycle until all MAX_ENTRIES slots are clear, and no request is accepted meanwhile.
// ----------------------------------------------------------------------------
// Message hash presence cache
// Direct-mapped cache of 128-bit message hashes with present flags and
// hit and fill statistics.
// ----------------------------------------------------------------------------
module message_hash_presence_cache_unit #(
  parameter int MAX_ENTRIES = msh_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [msh_pkg::CFG_W-1:0] cfg_wdata,
  msh_in_if.sink                    in_ch,
  msh_out_if.source                 out_ch
);
  localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic              clearing;
  logic              q_push, q_full, q_pop, q_empty;
  msh_pkg::cmd_t     push_cmd, head_cmd;
  logic [SLOT_W-1:0] push_slot, head_slot;

  msh_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SLOT_W      (SLOT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_slot    (push_slot)
  );

  msh_queue #(
    .SLOT_W (SLOT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .push_slot (push_slot),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_slot (head_slot)
  );

  msh_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SLOT_W      (SLOT_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .q_empty  (q_empty),
    .q_cmd    (head_cmd),
    .q_slot   (head_slot),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );
endmodule
